// ----- rtl/core/acgt_pkg.sv -----
// Shared types and codes for the goal transition decoder.
`timescale 1ns / 1ps

package acgt_pkg;

   localparam int SEQ_FIELD_W = 32;

   typedef enum logic [1:0] {
      GS_EXECUTING = 2'd0,
      GS_CANCELING = 2'd1,
      GS_FINISHING = 2'd2,
      GS_NONE      = 2'd3
   } goal_state_type;

   typedef enum logic [1:0] {
      TS_UNSPEC    = 2'd0,
      TS_SUCCEEDED = 2'd1,
      TS_CANCELED  = 2'd2,
      TS_ABORTED   = 2'd3
   } term_status_type;

   typedef enum logic [1:0] {
      KIND_NOP  = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_CONTEXT     = 3'd1,
      ERR_NOT_ALLOWED = 3'd2,
      ERR_ALREADY     = 3'd3,
      ERR_UNKNOWN     = 3'd4
   } err_type;

   localparam logic [3:0] ACT_CANCEL_REQ    = 4'd0;
   localparam logic [3:0] ACT_FEEDBACK      = 4'd1;
   localparam logic [3:0] ACT_CANCEL_ACCEPT = 4'd2;
   localparam logic [3:0] ACT_CANCEL_REJECT = 4'd3;
   localparam logic [3:0] ACT_RESULT        = 4'd4;
   localparam logic [3:0] ACT_CANCEL_FAIL   = 4'd5;
   localparam logic [3:0] ACT_IGNORE_0      = 4'd6;
   localparam logic [3:0] ACT_IGNORE_1      = 4'd7;
   localparam logic [3:0] ACT_IGNORE_2      = 4'd8;
   localparam logic [3:0] ACT_IGNORE_3      = 4'd9;

   typedef struct packed {
      logic [SEQ_FIELD_W-1:0] expected_seq;
      logic [1:0]             end_status;
      logic                   res_wait;
      logic                   cancel_pending;
      logic [1:0]             goal_state;
   } context_type;

   typedef struct packed {
      logic [3:0]             action;
      logic [SEQ_FIELD_W-1:0] event_sequence;
      logic [1:0]             event_status;
      context_type            ctx;
   } request_type;

   typedef struct packed {
      err_type     error_code;
      kind_type    transition_kind;
      context_type ctx;
   } response_type;

endpackage

// ----- rtl/core/acgt_decode.sv -----
// Combinational decode of one goal context and one client event.
`timescale 1ns / 1ps

module acgt_decode
   import acgt_pkg::*;
#(
   parameter int SEQ_WIDTH = 32
) (
   input  request_type  req,
   output response_type rsp
);

   localparam int EW = (SEQ_WIDTH < SEQ_FIELD_W) ? SEQ_WIDTH : SEQ_FIELD_W;

   logic          ctx_ok;
   logic [EW-1:0] seq_lo;
   logic [EW-1:0] seq_inc;
   logic          seq_match;
   logic          cancel_open;
   logic          result_fits;
   context_type   held;

   always_comb begin
      seq_lo    = req.ctx.expected_seq[EW-1:0];
      seq_inc   = seq_lo + EW'(1);
      seq_match = (req.event_sequence[EW-1:0] == seq_lo);

      held              = req.ctx;
      held.expected_seq = SEQ_FIELD_W'(seq_lo);

      ctx_ok = 1'b1;
      if (req.ctx.goal_state == GS_NONE) begin
         ctx_ok = 1'b0;
      end else if (req.ctx.cancel_pending && req.ctx.goal_state != GS_EXECUTING) begin
         ctx_ok = 1'b0;
      end else if (req.ctx.goal_state == GS_FINISHING) begin
         ctx_ok = !req.ctx.res_wait && req.ctx.end_status != TS_UNSPEC;
      end else begin
         ctx_ok = req.ctx.res_wait && req.ctx.end_status == TS_UNSPEC;
      end

      cancel_open = (req.ctx.goal_state == GS_EXECUTING) && req.ctx.cancel_pending;
      result_fits =
         (req.ctx.goal_state == GS_EXECUTING &&
          (req.event_status == TS_SUCCEEDED || req.event_status == TS_ABORTED)) ||
         (req.ctx.goal_state == GS_CANCELING &&
          (req.event_status == TS_CANCELED || req.event_status == TS_ABORTED));

      rsp.ctx             = held;
      rsp.transition_kind = KIND_NOP;
      rsp.error_code      = ERR_NONE;

      if (!ctx_ok) begin
         rsp.transition_kind = KIND_ERR;
         rsp.error_code      = ERR_CONTEXT;
      end else begin
         unique case (req.action)
            ACT_CANCEL_REQ: begin
               if (req.ctx.goal_state != GS_EXECUTING) begin
                  rsp.transition_kind = KIND_ERR;
                  rsp.error_code      = ERR_NOT_ALLOWED;
               end else if (req.ctx.cancel_pending) begin
                  rsp.transition_kind = KIND_ERR;
                  rsp.error_code      = ERR_ALREADY;
               end else begin
                  rsp.transition_kind    = KIND_DONE;
                  rsp.ctx.cancel_pending = 1'b1;
               end
            end
            ACT_FEEDBACK: begin
               if (req.ctx.goal_state != GS_FINISHING && seq_match) begin
                  rsp.transition_kind  = KIND_DONE;
                  rsp.ctx.expected_seq = SEQ_FIELD_W'(seq_inc);
               end
            end
            ACT_CANCEL_ACCEPT: begin
               if (cancel_open) begin
                  rsp.transition_kind    = KIND_DONE;
                  rsp.ctx.goal_state     = GS_CANCELING;
                  rsp.ctx.cancel_pending = 1'b0;
               end
            end
            ACT_CANCEL_REJECT: begin
               if (cancel_open) begin
                  rsp.transition_kind    = KIND_DONE;
                  rsp.ctx.cancel_pending = 1'b0;
               end
            end
            ACT_RESULT: begin
               if (result_fits) begin
                  rsp.transition_kind    = KIND_DONE;
                  rsp.ctx.goal_state     = GS_FINISHING;
                  rsp.ctx.cancel_pending = 1'b0;
                  rsp.ctx.res_wait       = 1'b0;
                  rsp.ctx.end_status     = req.event_status;
               end
            end
            ACT_CANCEL_FAIL: begin
               if (cancel_open) begin
                  rsp.transition_kind    = KIND_DONE;
                  rsp.ctx.cancel_pending = 1'b0;
               end else begin
                  rsp.transition_kind = KIND_ERR;
                  rsp.error_code      = ERR_NOT_ALLOWED;
               end
            end
            ACT_IGNORE_0, ACT_IGNORE_1, ACT_IGNORE_2, ACT_IGNORE_3: begin
               rsp.transition_kind = KIND_NOP;
            end
            default: begin
               rsp.transition_kind = KIND_ERR;
               rsp.error_code      = ERR_UNKNOWN;
            end
         endcase
      end
   end

endmodule

// ----- rtl/core/action_client_goal_transition.sv -----
// Top level: registered goal transition decoder with stream ports.
//
//  channel  | dir | tdata (low bit up)                         | tuser (low bit up)
//  ---------+-----+--------------------------------------------+----------------------------
//  req_     | in  | event_sequence 32, event_status 2,         | action 4
//           |     | cur_goal_state 2, cur_cancel_pending 1,    |
//           |     | cur_res_wait 1, cur_end_status 2,          |
//           |     | cur_expected_seq 32                        |
//  rsp_     | out | next_goal_state 2, next_cancel_pending 1,  | transition_kind 2,
//           |     | next_res_wait 1, next_end_status 2,        | error_code 3
//           |     | next_expected_seq 32, zero pad 2           |
//
// One item per cycle while the result is not stalled; a taken item goes to the input register,
// which feeds the decode, and the decode loads the result register once it is free or being read.
// Reset clears both valid flags; no state survives between items.
// A stalled result holds the result register, and the input register keeps
// taking items until it too is full.
`timescale 1ns / 1ps

module action_client_goal_transition
   import acgt_pkg::*;
#(
   parameter int SEQ_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // event_sequence, event_status, cur_goal_state,
                                   // cur_cancel_pending, cur_res_wait,
                                   // cur_end_status, cur_expected_seq
   input  logic [3:0]  req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // next_goal_state, next_cancel_pending,
                                   // next_res_wait, next_end_status,
                                   // next_expected_seq, zero pad
   output logic [4:0]  rsp_tuser   // transition_kind, error_code
);

   logic         in_valid_ff;
   logic         in_valid_in;
   request_type  in_data_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   response_type out_data_ff;
   response_type dec_rsp;
   logic         out_load;

   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;

   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   acgt_decode #(
      .SEQ_WIDTH(SEQ_WIDTH)
   ) u_decode (
      .req(in_data_ff),
      .rsp(dec_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff.action                  <= req_tuser;
         in_data_ff.event_sequence          <= req_tdata[31:0];
         in_data_ff.event_status            <= req_tdata[33:32];
         in_data_ff.ctx.goal_state          <= req_tdata[35:34];
         in_data_ff.ctx.cancel_pending      <= req_tdata[36];
         in_data_ff.ctx.res_wait            <= req_tdata[37];
         in_data_ff.ctx.end_status          <= req_tdata[39:38];
         in_data_ff.ctx.expected_seq        <= req_tdata[71:40];
      end
      if (out_load) begin
         out_data_ff <= dec_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00,
                        out_data_ff.ctx.expected_seq,
                        out_data_ff.ctx.end_status,
                        out_data_ff.ctx.res_wait,
                        out_data_ff.ctx.cancel_pending,
                        out_data_ff.ctx.goal_state};
   assign rsp_tuser  = {out_data_ff.error_code, out_data_ff.transition_kind};

endmodule

// ----- rtl/core/acgt_checker.sv -----
// Port-level checks for the goal transition decoder, bound to the top level.
`timescale 1ns / 1ps

module acgt_checker
   import acgt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [4:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser[1:0] == KIND_ERR) == (rsp_tuser[4:2] != ERR_NONE)))
      else $error("error code disagrees with transition kind");

   a_done_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_DONE |->
         rsp_tdata[1:0] != GS_NONE && !(rsp_tdata[2] && rsp_tdata[1:0] != GS_EXECUTING))
      else $error("transition produced an inconsistent context");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind action_client_goal_transition acgt_checker u_acgt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
